FILE: hw/rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// shared field widths, register codes and constants of the max-flow block
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int NODE_IDX_W  = 3;
  localparam int CAP_FIELD_W = 16;
  localparam int FLOW_W      = 19;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 3;

  // starting bottleneck of a search and the bits needed to hold it
  localparam int unsigned INFINITE_FLOW = 100000000;
  localparam int          INF_BITS      = 27;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE = 1'b0,
    CFG_SINK   = 1'b1
  } cfg_reg_t;

endpackage

FILE: hw/rtl/mfd_in_if.sv
// ----------------------------------------------------------------------------
// mfd_in_if
// load channel: one capacity entry per item
// ----------------------------------------------------------------------------
interface mfd_in_if;
  logic                             valid;
  logic                             ready;
  logic [mfd_pkg::NODE_IDX_W-1:0]   from_node;
  logic [mfd_pkg::NODE_IDX_W-1:0]   to_node;
  logic [mfd_pkg::CAP_FIELD_W-1:0]  capacity;
  logic                             last_entry;

  modport source (output valid, from_node, to_node, capacity, last_entry, input ready);
  modport sink   (input valid, from_node, to_node, capacity, last_entry, output ready);
endinterface

FILE: hw/rtl/mfd_out_if.sv
// ----------------------------------------------------------------------------
// mfd_out_if
// result channel: total flow and bad request flag
// ----------------------------------------------------------------------------
interface mfd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mfd_pkg::FLOW_W-1:0]  flow_value;
  logic                        bad_request;

  modport source (output valid, flow_value, bad_request, input ready);
  modport sink   (input valid, flow_value, bad_request, output ready);
endinterface

FILE: hw/rtl/mfd_cfg_if.sv
// ----------------------------------------------------------------------------
// mfd_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface mfd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mfd_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [mfd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

FILE: hw/rtl/mfd_ram.sv
// ----------------------------------------------------------------------------
// mfd_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/max_flow_dfs_augment_top.sv
// ----------------------------------------------------------------------------
// max_flow_dfs_augment_top
// ford-fulkerson max flow with depth-first augmenting paths over a ram store
// ----------------------------------------------------------------------------
// load items: one per cycle, accepted while idle
// search: a start per search, a skip per visited neighbour, probes of neighbours,
//   pushes, pops and per path edge two reads and two writes; probes and edge reads
//   share the single read port of the residual ram, pops read the stack ram
// result: loaded in the finish state, once the result register is free
// clearing pass: over every residual ram entry after reset and after each result,
//   no item accepted meanwhile; registers reset to source 0, sink 7
module max_flow_dfs_augment_top #(
  parameter int NODE_COUNT    = 8,
  parameter int CAPACITY_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  mfd_in_if.sink    in_ch,
  mfd_out_if.source out_ch,
  mfd_cfg_if.sink   cfg_ch
);
  import mfd_pkg::*;

  localparam int NW     = $clog2(NODE_COUNT);
  localparam int RW     = CAPACITY_BITS + 1;
  localparam int BW     = (RW > INF_BITS) ? RW : INF_BITS;
  localparam int MAW    = 2 * NW;
  localparam int MDEPTH = 1 << MAW;
  localparam int SW     = NW + NW + 1 + BW;

  localparam logic [BW-1:0] INF      = BW'(INFINITE_FLOW);
  localparam logic [RW-1:0] CAP_MASK = {1'b0, {CAPACITY_BITS{1'b1}}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INIT, S_TOP, S_SCAN_RD, S_SCAN_CHK, S_POP, S_POP_WAIT,
    S_AUG_NEXT, S_AUG_GET, S_EDGE_RD1, S_EDGE_WR1, S_EDGE_WR2, S_FINISH
  } state_t;

  state_t                  state_r;
  logic [NODE_IDX_W-1:0]   src_r, snk_r;
  logic [MAW-1:0]          clr_addr_r;
  logic [NW-1:0]           u_r, a_r, b_r;
  logic [NW:0]             sp_r, depth_r, idx_r;
  logic [BW-1:0]           bn_r;
  logic [NODE_COUNT-1:0]   visited_r;
  logic [FLOW_W-1:0]       flow_r, out_flow_r;
  logic                    bad_r, out_bad_r, out_valid_r;

  logic           m_we;
  logic [MAW-1:0] m_waddr, m_raddr;
  logic [RW-1:0]  m_wdata, m_rdata;
  logic           s_we;
  logic [NW-1:0]  s_waddr, s_raddr;
  logic [SW-1:0]  s_wdata, s_rdata;

  logic          in_acc, from_ok, to_ok, src_ok, snk_ok, push_ok;
  logic [NW-1:0] src_n, snk_n;
  logic [BW-1:0] e_ext;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.flow_value  = out_flow_r;
  assign out_ch.bad_request = out_bad_r;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign from_ok = int'(in_ch.from_node) < NODE_COUNT;
  assign to_ok   = int'(in_ch.to_node) < NODE_COUNT;
  assign src_ok  = int'(src_r) < NODE_COUNT;
  assign snk_ok  = int'(snk_r) < NODE_COUNT;
  assign src_n   = NW'(src_r);
  assign snk_n   = NW'(snk_r);
  assign e_ext   = BW'(m_rdata);
  assign push_ok = int'(depth_r) < NODE_COUNT;

  mfd_ram #(.WIDTH(RW), .DEPTH(MDEPTH)) u_resid_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  // frames below the top of the search stack: node, scan position, bottleneck
  mfd_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_stack_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  always_comb begin
    m_we    = 1'b0;
    m_waddr = '0;
    m_wdata = '0;
    m_raddr = '0;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = '0;
    unique case (state_r)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_addr_r;
      end
      S_IDLE: begin
        m_we    = in_acc && from_ok && to_ok;
        m_waddr = {NW'(in_ch.from_node), NW'(in_ch.to_node)};
        m_wdata = RW'(in_ch.capacity) & CAP_MASK;
      end
      S_SCAN_RD: m_raddr = {u_r, sp_r[NW-1:0]};
      S_SCAN_CHK: begin
        s_we    = (m_rdata != '0) && push_ok;
        s_waddr = NW'(depth_r - 1'b1);
        s_wdata = {u_r, sp_r + 1'b1, bn_r};
      end
      S_POP:      s_raddr = NW'(depth_r - 2'd2);
      S_AUG_NEXT: s_raddr = NW'(idx_r);
      S_EDGE_RD1: m_raddr = {a_r, b_r};
      S_EDGE_WR1: begin
        // forward entry drops, reverse entry is fetched in the same cycle
        m_we    = 1'b1;
        m_waddr = {a_r, b_r};
        m_wdata = m_rdata - RW'(bn_r);
        m_raddr = {b_r, a_r};
      end
      S_EDGE_WR2: begin
        m_we    = 1'b1;
        m_waddr = {b_r, a_r};
        m_wdata = m_rdata + RW'(bn_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      src_r       <= '0;
      snk_r       <= NODE_IDX_W'(7);
      out_valid_r <= 1'b0;
      flow_r      <= '0;
      bad_r       <= 1'b0;
      visited_r   <= '0;
      depth_r     <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_reg_t'(cfg_ch.reg_index))
          CFG_SOURCE: src_r <= cfg_ch.data;
          CFG_SINK:   snk_r <= cfg_ch.data;
        endcase
      end
      // the finish state reloads the result register itself
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == MAW'(MDEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && in_ch.last_entry) begin
            flow_r <= '0;
            bad_r  <= (src_r == snk_r);
            if (src_r == snk_r) begin
              state_r <= S_FINISH;
            end else if (src_ok && snk_ok) begin
              state_r <= S_INIT;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_INIT: begin
          u_r       <= src_n;
          sp_r      <= '0;
          bn_r      <= INF;
          depth_r   <= (NW+1)'(1);
          visited_r <= NODE_COUNT'(1) << src_n;
          state_r   <= S_TOP;
        end
        S_TOP: begin
          if (u_r == snk_n) begin
            a_r     <= src_n;
            idx_r   <= (NW+1)'(1);
            state_r <= S_AUG_NEXT;
          end else begin
            state_r <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (int'(sp_r) >= NODE_COUNT) begin
            state_r <= S_POP;
          end else if (visited_r[sp_r[NW-1:0]]) begin
            sp_r <= sp_r + 1'b1;
          end else begin
            state_r <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (m_rdata == '0) begin
            sp_r    <= sp_r + 1'b1;
            state_r <= S_SCAN_RD;
          end else if (push_ok) begin
            u_r                     <= sp_r[NW-1:0];
            sp_r                    <= '0;
            bn_r                    <= (e_ext < bn_r) ? e_ext : bn_r;
            visited_r[sp_r[NW-1:0]] <= 1'b1;
            depth_r                 <= depth_r + 1'b1;
            state_r                 <= S_TOP;
          end else begin
            state_r <= S_POP;
          end
        end
        S_POP: begin
          depth_r <= depth_r - 1'b1;
          // stack empties: no augmenting path left
          if (depth_r == (NW+1)'(1)) begin
            state_r <= S_FINISH;
          end else begin
            state_r <= S_POP_WAIT;
          end
        end
        S_POP_WAIT: begin
          {u_r, sp_r, bn_r} <= s_rdata;
          state_r           <= S_SCAN_RD;
        end
        S_AUG_NEXT: begin
          if (idx_r < depth_r - 1'b1) begin
            state_r <= S_AUG_GET;
          end else begin
            b_r     <= u_r;
            state_r <= S_EDGE_RD1;
          end
        end
        S_AUG_GET: begin
          b_r     <= s_rdata[SW-1 -: NW];
          state_r <= S_EDGE_RD1;
        end
        S_EDGE_RD1: state_r <= S_EDGE_WR1;
        S_EDGE_WR1: state_r <= S_EDGE_WR2;
        S_EDGE_WR2: begin
          a_r   <= b_r;
          idx_r <= idx_r + 1'b1;
          if (b_r == snk_n) begin
            flow_r  <= flow_r + FLOW_W'(bn_r);
            state_r <= S_INIT;
          end else begin
            state_r <= S_AUG_NEXT;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_flow_r  <= flow_r;
            out_bad_r   <= bad_r;
            clr_addr_r  <= '0;
            state_r     <= S_CLEAR;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

endmodule
